// File: rtl/ldti_pkg.sv
// Shared types, constants and elaboration-time helpers for the log-domain
// table interpolator. No dependencies.
`default_nettype none

package ldti_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZERO  = 2'd2,
    ST_LOAD  = 2'd3
  } status_e;

  localparam int unsigned GRID_START = 6144;
  localparam int unsigned GRID_SHIFT = 10;
  localparam int unsigned T_BITS     = 10;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned X_BITS     = 31;
  localparam logic [31:0] RATE_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              interp;
    status_e           status;
    logic [T_BITS-1:0] t;
    logic [31:0]       rate;
  } item_ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] nn;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    nn  = n;
    for (int i = 0; i < 32; i++) begin
      if (nn >= res + bt) begin
        nn  = nn - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.30, truncated at each root
  function automatic logic [X_BITS-1:0] exp2_coef(input int k);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[X_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/log_domain_table_interpolator_unit.sv
// Log-domain table interpolator, top level: front, queues, back end.
// Throughput: one item per cycle, loads and queries alike, while the receiver keeps popping results.
// Reset clears all control state; the sample table is not cleared and
// holds undefined data until written.
`default_nettype none

module log_domain_table_interpolator_unit #(
  parameter int NUM_POINTS  = 33,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        op_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire logic [31:0] entry_value_i,
  input  wire logic [15:0] energy_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      rate_o,
  output logic [1:0]       status_o
);

  import ldti_pkg::*;

  localparam int CTL_BITS = $bits(item_ctl_t);
  localparam int MID_W    = CTL_BITS + 2 * SAMPLE_BITS;

  logic                   f_push, m_full, m_empty, m_pop;
  item_ctl_t              f_ctl, m_ctl;
  logic [SAMPLE_BITS-1:0] f_v0, f_v1, m_v0, m_v1;
  logic [MID_W-1:0]       m_rdata;
  logic                   r_push, r_full;
  logic [31:0]            r_rate;
  logic [1:0]             r_status;
  logic [33:0]            r_rdata;
  logic                   pop_ok;

  ldti_front #(.NUM_POINTS(NUM_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .energy_i      (energy_i),
    .q_push_o      (f_push),
    .q_full_i      (m_full),
    .q_ctl_o       (f_ctl),
    .q_v0_o        (f_v0),
    .q_v1_o        (f_v1)
  );

  ldti_fifo #(.WIDTH(MID_W), .DEPTH(4)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_ctl, f_v0, f_v1}),
    .full_o  (m_full),
    .pop_i   (m_pop),
    .rdata_o (m_rdata),
    .empty_o (m_empty)
  );

  assign m_ctl = m_rdata[MID_W-1 -: CTL_BITS];
  assign m_v0  = m_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign m_v1  = m_rdata[SAMPLE_BITS-1:0];

  ldti_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (m_empty),
    .q_pop_o    (m_pop),
    .q_ctl_i    (m_ctl),
    .q_v0_i     (m_v0),
    .q_v1_i     (m_v1),
    .r_full_i   (r_full),
    .r_push_o   (r_push),
    .r_rate_o   (r_rate),
    .r_status_o (r_status)
  );

  assign pop_ok = pop && !empty;

  ldti_fifo #(.WIDTH(34), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .wdata_i ({r_status, r_rate}),
    .full_o  (r_full),
    .pop_i   (pop_ok),
    .rdata_o (r_rdata),
    .empty_o (empty)
  );

  assign rate_o   = r_rdata[31:0];
  assign status_o = r_rdata[33:32];

endmodule

`default_nettype wire

// File: rtl/ldti_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on nothing.
`default_nettype none

module ldti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after push");

endmodule

`default_nettype wire

// File: rtl/ldti_front.sv
// Front end: accepts items, owns the sample table, classifies queries.
// Depends on ldti_pkg.
`default_nettype none

module ldti_front #(
  parameter int NUM_POINTS  = 33,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  output logic                         full_o,
  input  wire logic                    op_i,
  input  wire logic [5:0]              entry_index_i,
  input  wire logic [31:0]             entry_value_i,
  input  wire logic [15:0]             energy_i,
  output logic                         q_push_o,
  input  wire logic                    q_full_i,
  output ldti_pkg::item_ctl_t          q_ctl_o,
  output logic [SAMPLE_BITS-1:0]       q_v0_o,
  output logic [SAMPLE_BITS-1:0]       q_v1_o
);

  import ldti_pkg::*;

  localparam int AW = $clog2(NUM_POINTS);
  localparam int SB = SAMPLE_BITS;
  localparam logic [16:0] TOP_E =
    17'(GRID_START + (NUM_POINTS - 1) * (1 << GRID_SHIFT));

  logic [SB-1:0] mem_q [NUM_POINTS];
  logic [SB-1:0] rd0_q, rd1_q;
  logic          f1_valid_q;
  logic          op_q, oor_q, last_q;
  logic [T_BITS-1:0] t_q;

  logic          accept, wr_en, below, above, last;
  logic [16:0]   offset;
  logic [5:0]    idx;
  logic [AW-1:0] ra0, ra1;
  logic [SB-1:0] wval;
  logic [SB+31:0] v0w;
  logic [31:0]   sat_v0;
  logic          z0, z1;

  assign full_o   = f1_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = f1_valid_q && !q_full_i;

  assign offset = {1'b0, energy_i} - 17'(GRID_START);
  assign below  = energy_i < 16'(GRID_START);
  assign above  = {1'b0, energy_i} > TOP_E;
  assign idx    = offset[15:10];
  assign last   = {1'b0, idx} >= 7'(NUM_POINTS - 1);
  assign ra0    = last ? AW'(NUM_POINTS - 1) : idx[AW-1:0];
  assign ra1    = last ? ra0 : ra0 + AW'(1);
  assign wval   = SB'(entry_value_i);
  assign wr_en  = accept && !op_i && ({1'b0, entry_index_i} < 7'(NUM_POINTS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i[AW-1:0]] <= wval;
    end
    if (accept) begin
      rd0_q  <= mem_q[ra0];
      rd1_q  <= mem_q[ra1];
      op_q   <= op_i;
      oor_q  <= below || above;
      last_q <= last;
      t_q    <= offset[T_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (accept) begin
      f1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      f1_valid_q <= 1'b0;
    end
  end

  assign v0w    = (SB+32)'(rd0_q);
  assign sat_v0 = (|v0w[SB+31:32]) ? RATE_MAX : v0w[31:0];
  assign z0     = rd0_q == '0;
  assign z1     = rd1_q == '0;

  always_comb begin
    q_ctl_o.interp = 1'b0;
    q_ctl_o.status = ST_OK;
    q_ctl_o.t      = t_q;
    q_ctl_o.rate   = '0;
    if (!op_q) begin
      q_ctl_o.status = ST_LOAD;
    end else if (oor_q) begin
      q_ctl_o.status = ST_RANGE;
    end else if (last_q) begin
      if (z0) begin
        q_ctl_o.status = ST_ZERO;
      end else begin
        q_ctl_o.rate = sat_v0;
      end
    end else if (z0 || z1) begin
      q_ctl_o.status = ST_ZERO;
    end else if (t_q == '0) begin
      q_ctl_o.rate = sat_v0;
    end else begin
      q_ctl_o.interp = 1'b1;
    end
  end

  assign q_v0_o = rd0_q;
  assign q_v1_o = rd1_q;

endmodule

`default_nettype wire

// File: rtl/ldti_log2.sv
// Pipelined log2 in Q.16: staged leading-one search, then 16 squaring steps.
// Depends on ldti_pkg.
`default_nettype none

module ldti_log2 #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [SAMPLE_BITS-1:0] v_i,
  output logic [$clog2(2**$clog2((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32))+15:0] l_o
);

  import ldti_pkg::*;

  localparam int W      = 2**$clog2((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32);
  localparam int E_BITS = $clog2(W);

  logic [W-1:0]      w_q  [E_BITS];
  logic [E_BITS-1:0] lz_q [E_BITS];
  logic [X_BITS-1:0]    x_q  [FRAC_BITS];
  logic [FRAC_BITS-1:0] fr_q [FRAC_BITS];
  logic [E_BITS-1:0]    e_q  [FRAC_BITS];

  for (genvar s = 0; s < E_BITS; s++) begin : g_norm
    localparam int S = W >> (s + 1);
    logic [W-1:0]      w_in;
    logic [E_BITS-1:0] lz_in;
    if (s == 0) begin : g_first
      assign w_in  = W'(v_i);
      assign lz_in = '0;
    end else begin : g_next
      assign w_in  = w_q[s-1];
      assign lz_in = lz_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (w_in[W-1 -: S] == '0) begin
          w_q[s]  <= w_in << S;
          lz_q[s] <= lz_in | E_BITS'(S);
        end else begin
          w_q[s]  <= w_in;
          lz_q[s] <= lz_in;
        end
      end
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
    logic [X_BITS-1:0]    x_in;
    logic [FRAC_BITS-1:0] fr_in;
    logic [E_BITS-1:0]    e_in;
    logic [2*X_BITS-1:0]  p;
    logic [31:0]          y;
    if (j == 0) begin : g_first
      assign x_in  = w_q[E_BITS-1][W-1 -: X_BITS];
      assign fr_in = '0;
      assign e_in  = E_BITS'(W - 1) - lz_q[E_BITS-1];
    end else begin : g_next
      assign x_in  = x_q[j-1];
      assign fr_in = fr_q[j-1];
      assign e_in  = e_q[j-1];
    end
    assign p = x_in * x_in;
    assign y = p[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[j] <= e_in;
        if (y[31]) begin
          x_q[j]  <= y[31:1];
          fr_q[j] <= {fr_in[FRAC_BITS-2:0], 1'b1};
        end else begin
          x_q[j]  <= y[30:0];
          fr_q[j] <= {fr_in[FRAC_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign l_o = {e_q[FRAC_BITS-1], fr_q[FRAC_BITS-1]};

endmodule

`default_nettype wire

// File: rtl/ldti_back.sv
// Back end: two log2 pipes, log-domain blend, exp2 pipe, rounding.
// Depends on ldti_pkg and ldti_log2.
`default_nettype none

module ldti_back #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_empty_i,
  output logic                        q_pop_o,
  input  wire ldti_pkg::item_ctl_t    q_ctl_i,
  input  wire logic [SAMPLE_BITS-1:0] q_v0_i,
  input  wire logic [SAMPLE_BITS-1:0] q_v1_i,
  input  wire logic                   r_full_i,
  output logic                        r_push_o,
  output logic [31:0]                 r_rate_o,
  output logic [1:0]                  r_status_o
);

  import ldti_pkg::*;

  localparam int W       = 2**$clog2((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32);
  localparam int E_BITS  = $clog2(W);
  localparam int L_BITS  = E_BITS + FRAC_BITS;
  localparam int LOG_LAT = E_BITS + FRAC_BITS;
  localparam int P_BITS  = L_BITS + T_BITS + 1;
  localparam logic [62:0] HALF = 63'(1) << 29;

  logic en;
  logic [L_BITS-1:0] l0, l1;

  item_ctl_t sb_ctl_q [LOG_LAT];
  logic      sb_v_q   [LOG_LAT];

  item_ctl_t b1_ctl_q, b2_ctl_q;
  logic      b1_v_q, b2_v_q;
  logic [P_BITS-1:0] p0_q, p1_q;
  logic [P_BITS:0]   lsum;
  logic [L_BITS-1:0] b2_l_q;
  logic [E_BITS-1:0] n_full;

  logic [X_BITS-1:0]    acc_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] f_q   [FRAC_BITS];
  logic [4:0]           n_q   [FRAC_BITS];
  logic                 ovf_q [FRAC_BITS];
  item_ctl_t            ex_ctl_q [FRAC_BITS];
  logic                 ex_v_q   [FRAC_BITS];

  logic        fin_v_q;
  logic [31:0] fin_rate_q, fin_rate_d;
  logic [1:0]  fin_status_q;
  logic [62:0] shv, rnd;

  assign en       = !fin_v_q || !r_full_i;
  assign q_pop_o  = en && !q_empty_i;
  assign r_push_o = fin_v_q && !r_full_i;

  ldti_log2 #(.SAMPLE_BITS(SAMPLE_BITS)) u_log0 (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (q_v0_i),
    .l_o   (l0)
  );

  ldti_log2 #(.SAMPLE_BITS(SAMPLE_BITS)) u_log1 (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (q_v1_i),
    .l_o   (l1)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_ctl_q[0] <= q_ctl_i;
      for (int i = 1; i < LOG_LAT; i++) begin
        sb_ctl_q[i] <= sb_ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOG_LAT; i++) begin
        sb_v_q[i] <= 1'b0;
      end
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else if (en) begin
      sb_v_q[0] <= q_pop_o;
      for (int i = 1; i < LOG_LAT; i++) begin
        sb_v_q[i] <= sb_v_q[i-1];
      end
      b1_v_q <= sb_v_q[LOG_LAT-1];
      b2_v_q <= b1_v_q;
    end
  end

  // blend: L = (L0*(1024-t) + L1*t + 512) >> 10
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_ctl_q <= sb_ctl_q[LOG_LAT-1];
      p0_q <= P_BITS'(l0) * P_BITS'((T_BITS+1)'(1 << T_BITS) -
                                    {1'b0, sb_ctl_q[LOG_LAT-1].t});
      p1_q <= P_BITS'(l1) * P_BITS'(sb_ctl_q[LOG_LAT-1].t);
      b2_ctl_q <= b1_ctl_q;
      b2_l_q   <= lsum[L_BITS+T_BITS-1:T_BITS];
    end
  end

  assign lsum   = {1'b0, p0_q} + {1'b0, p1_q} + (P_BITS+1)'(1 << (GRID_SHIFT - 1));
  assign n_full = b2_l_q[L_BITS-1:FRAC_BITS];

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_exp
    localparam logic [X_BITS-1:0] CK = exp2_coef(j + 1);
    logic [X_BITS-1:0]    acc_in;
    logic [FRAC_BITS-1:0] f_in;
    logic [4:0]           n_in;
    logic                 ovf_in;
    item_ctl_t            ctl_in;
    logic                 v_in;
    logic [2*X_BITS-1:0]  prod;
    if (j == 0) begin : g_first
      assign acc_in = X_BITS'(1) << 30;
      assign f_in   = b2_l_q[FRAC_BITS-1:0];
      assign n_in   = n_full[4:0];
      assign ovf_in = n_full > E_BITS'(31);
      assign ctl_in = b2_ctl_q;
      assign v_in   = b2_v_q;
    end else begin : g_next
      assign acc_in = acc_q[j-1];
      assign f_in   = f_q[j-1];
      assign n_in   = n_q[j-1];
      assign ovf_in = ovf_q[j-1];
      assign ctl_in = ex_ctl_q[j-1];
      assign v_in   = ex_v_q[j-1];
    end
    assign prod = acc_in * CK;
    always_ff @(posedge clk_i) begin
      if (en) begin
        acc_q[j]    <= f_in[FRAC_BITS-1-j] ? prod[60:30] : acc_in;
        f_q[j]      <= f_in;
        n_q[j]      <= n_in;
        ovf_q[j]    <= ovf_in;
        ex_ctl_q[j] <= ctl_in;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_v_q[j] <= 1'b0;
      end else if (en) begin
        ex_v_q[j] <= v_in;
      end
    end
  end

  assign shv = 63'(acc_q[FRAC_BITS-1]) << n_q[FRAC_BITS-1];
  assign rnd = shv + HALF;

  always_comb begin
    if (!ex_ctl_q[FRAC_BITS-1].interp) begin
      fin_rate_d = ex_ctl_q[FRAC_BITS-1].rate;
    end else if (ovf_q[FRAC_BITS-1] || rnd[62]) begin
      fin_rate_d = RATE_MAX;
    end else begin
      fin_rate_d = rnd[61:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_rate_q   <= fin_rate_d;
      fin_status_q <= ex_ctl_q[FRAC_BITS-1].status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= ex_v_q[FRAC_BITS-1];
    end
  end

  assign r_rate_o   = fin_rate_q;
  assign r_status_o = fin_status_q;

endmodule

`default_nettype wire

// File: tb/ldti_checker.sv
// Scoreboard for the log-domain table interpolator: watches both queue ports,
// predicts each result from its own copy of the sample table, and compares.
// Depends on ldti_pkg for the status codes, grid constants and RATE_MAX.
module ldti_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        op_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [15:0] energy_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [31:0] rate_i,
  input  logic [1:0]  status_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ldti_pkg::*;

  localparam int POINTS = 33;
  localparam logic OP_LOAD = 1'b0;
  localparam logic [15:0] ENERGY_TOP = 16'(GRID_START + ((POINTS - 1) << GRID_SHIFT));

  typedef struct {
    logic [31:0] rate;
    status_e     status;
  } rate_result_t;

  logic [31:0]  samples [POINTS];
  bit   [63:0]  root_coef [1:16];
  rate_result_t rate_q [$];

  function automatic bit [63:0] floor_sqrt(bit [63:0] n);
    bit [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= n) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic bit [63:0] log2_q16(bit [63:0] v);
    int e;
    bit [63:0] x, frac;
    e = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (v[i]) e = i;
    x = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic logic [31:0] exp2_q16(bit [63:0] l);
    bit [63:0] n, acc, r;
    n = l >> 16;
    acc = 64'd1 << 30;
    if (n >= 32) return RATE_MAX;
    for (int k = 1; k <= 16; k++) begin
      if (l[16 - k]) acc = (acc * root_coef[k]) >> 30;
    end
    r = ((acc << n) + (64'd1 << 29)) >> 30;
    return (r > 64'hFFFF_FFFF) ? RATE_MAX : r[31:0];
  endfunction

  function automatic rate_result_t predict_rate(logic op, logic [5:0] index,
                                                logic [31:0] value, logic [15:0] energy);
    rate_result_t res;
    bit [15:0] offset;
    int idx;
    bit [63:0] t, v0, v1, blend;
    res.rate = '0;
    if (op == OP_LOAD) begin
      if (index < POINTS) samples[index] = value;
      res.status = ST_LOAD;
      return res;
    end
    if (energy < GRID_START || energy > ENERGY_TOP) begin
      res.status = ST_RANGE;
      return res;
    end
    offset = energy - 16'(GRID_START);
    idx = offset >> GRID_SHIFT;
    t = offset[9:0];
    if (idx >= POINTS - 1) begin
      res.status = (samples[POINTS-1] == 0) ? ST_ZERO : ST_OK;
      res.rate = samples[POINTS-1];
      return res;
    end
    v0 = samples[idx];
    v1 = samples[idx+1];
    if (v0 == 0 || v1 == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    res.status = ST_OK;
    if (t == 0) begin
      res.rate = v0[31:0];
      return res;
    end
    blend = (log2_q16(v0) * (1024 - t) + log2_q16(v1) * t + 512) >> 10;
    res.rate = exp2_q16(blend);
    return res;
  endfunction

  initial begin
    bit [63:0] c;
    c = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      c = floor_sqrt(c << 30);
      root_coef[k] = c;
    end
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    rate_result_t want;
    if (rst_ni) begin
      if (push_i && !full_i)
        rate_q.push_back(predict_rate(op_i, entry_index_i, entry_value_i, energy_i));
      if (pop_i && !empty_i) begin
        if (rate_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("unexpected result transfer: rate=%0d status=%0d", rate_i, status_i);
        end else begin
          want = rate_q.pop_front();
          if (rate_i !== want.rate || status_i !== want.status) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: expected rate=%0d status=%0d, got rate=%0d status=%0d",
                       want.rate, want.status, rate_i, status_i);
          end
        end
      end
    end
    pending_o <= rate_q.size();
  end
endmodule

// File: tb/log_domain_table_interpolator_unit_tb.sv
// Top testbench for log_domain_table_interpolator_unit: clock, reset, bursty
// stimulus, receiver stalls and verdict. Depends on the unit and ldti_checker.
module log_domain_table_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic op_i = OP_LOAD;
  logic [5:0] entry_index_i = '0;
  logic [31:0] entry_value_i = '0;
  logic [15:0] energy_i = '0;
  logic pop = 1'b0;
  logic full, empty;
  logic [31:0] rate_o;
  logic [1:0] status_o;
  int errors, pending;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  log_domain_table_interpolator_unit dut (
    .clk_i, .rst_ni, .push, .full, .op_i, .entry_index_i, .entry_value_i,
    .energy_i, .empty, .pop, .rate_o, .status_o
  );

  ldti_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .op_i, .entry_index_i,
    .entry_value_i, .energy_i, .empty_i(empty), .pop_i(pop), .rate_i(rate_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending)
  );

  task automatic send_item(logic op, logic [5:0] index, logic [31:0] value,
                           logic [15:0] energy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    push <= 1'b1;
    op_i <= op;
    entry_index_i <= index;
    entry_value_i <= value;
    energy_i <= energy;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [15:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(6144 + 1024 * $urandom_range(0, 32));
      default: return 16'($urandom_range(6144, 38912));
    endcase
  endfunction

  // receiver: random stall mode that changes at random; no pops during hold-off
  always @(posedge clk_i) begin
    int mode;
    if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
    if (hold_off) pop <= 1'b0;
    else case (mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 2) == 0);
    endcase
  end

  initial begin
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(OP_QUERY, 6'd0, '0, 16'd0);
    send_item(OP_QUERY, 6'd0, '0, 16'd6143);
    send_item(OP_QUERY, 6'd0, '0, 16'd38913);
    send_item(OP_QUERY, 6'd0, '0, 16'hFFFF);
    for (int i = 0; i < 33; i++)
      send_item(OP_LOAD, 6'(i), (i == 5) ? 32'd0 : (i == 32) ? 32'hFFFF_FFFF :
                (i == 0) ? 32'd1 : pick_sample() | 32'd1, '0);
    send_item(OP_LOAD, 6'd33, 32'hFFFF_FFFF, '0);
    send_item(OP_LOAD, 6'd63, 32'hAAAA_5555, '0);
    send_item(OP_QUERY, 6'd63, '1, 16'd6144);
    send_item(OP_QUERY, 6'd0, '0, 16'd6145);
    send_item(OP_QUERY, 6'd0, '0, 16'd7167);
    send_item(OP_QUERY, 6'd0, '0, 16'd6144 + 16'd4096);
    send_item(OP_QUERY, 6'd0, '0, 16'd6144 + 16'd5120 + 16'd512);
    send_item(OP_QUERY, 6'd0, '0, 16'd38911);
    send_item(OP_QUERY, 6'd0, '0, 16'd38912);
    send_item(OP_LOAD, 6'd32, 32'd0, '0);
    send_item(OP_QUERY, 6'd0, '0, 16'd38912);
    send_item(OP_QUERY, 6'd0, '0, 16'd38000);
    for (int n = 0; n < 1550; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_LOAD, ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                  : 6'($urandom_range(0, 32)), pick_sample(), 16'($urandom));
      else
        send_item(OP_QUERY, 6'($urandom), $urandom, pick_energy());
    end
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// File: log_domain_table_interpolator_unit.f
rtl/ldti_pkg.sv
rtl/ldti_fifo.sv
rtl/ldti_front.sv
rtl/ldti_log2.sv
rtl/ldti_back.sv
rtl/log_domain_table_interpolator_unit.sv
tb/ldti_checker.sv
tb/log_domain_table_interpolator_unit_tb.sv
